// ----- rtl/acse_pkg.sv -----
package acse_pkg;

	localparam int MAX_SEQUENCE = 16;
	localparam int LEN_W = $clog2(MAX_SEQUENCE + 1);
	localparam int IDX_W = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_M        = 8'h6D;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_ESCAPE  = 2'd1,
		MODE_BRACKET = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_LB,
		S_BUF,
		S_TAB,
		S_BYTE
	} seq_state_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_done;
	} out_word_t;

	typedef struct packed {
		logic      req;
		out_word_t word;
	} emit_t;

endpackage

// ----- rtl/acse_ram.sv -----
module acse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/acse_seq.sv -----
module acse_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  acse_pkg::in_word_t text_data,
	input  logic               out_free,
	output acse_pkg::emit_t    emit
);

	acse_pkg::seq_state_t state_q, state_d;
	acse_pkg::mode_t      mode_q, mode_d;
	logic [acse_pkg::LEN_W-1:0] len_q, len_d;
	logic [acse_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [2:0]                 tab_q, tab_d;
	acse_pkg::in_word_t         item_q;

	logic       we;
	logic [7:0] rdata;
	logic [7:0] b;
	logic       eot;
	logic       legal;
	logic       tail_none;
	logic       at_end;
	logic       fin;
	logic       step_done;
	logic       accept;

	acse_ram #(
		.WIDTH(8),
		.DEPTH(acse_pkg::MAX_SEQUENCE)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(len_q[acse_pkg::IDX_W-1:0]),
		.wdata(b),
		.raddr(idx_d),
		.rdata(rdata)
	);

	assign b         = item_q.text_byte;
	assign eot       = item_q.end_of_text;
	assign legal     = (b >= acse_pkg::CH_DIGIT_LO && b <= acse_pkg::CH_DIGIT_HI) ||
		b == acse_pkg::CH_SEMI;
	assign tail_none = eot || b == acse_pkg::CH_ESC;
	assign at_end    = acse_pkg::LEN_W'(idx_q) ==
		acse_pkg::LEN_W'(len_q - acse_pkg::LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acse_pkg::S_IDLE;
			mode_q  <= acse_pkg::MODE_PLAIN;
			len_q   <= '0;
			idx_q   <= '0;
			tab_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			tab_q   <= tab_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= text_data;
		end
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		len_d     = len_q;
		idx_d     = idx_q;
		tab_d     = tab_q;
		emit      = '0;
		we        = 1'b0;
		fin       = 1'b0;
		step_done = 1'b0;

		unique case (state_q)
			acse_pkg::S_IDLE: begin
			end
			acse_pkg::S_DISPATCH: begin
				if (eot) begin
					emit.req = 1'b1;
					case (mode_q)
						acse_pkg::MODE_ESCAPE: begin
							emit.word.out_byte   = acse_pkg::CH_ESC;
							emit.word.byte_valid = 1'b1;
							emit.word.run_last   = 1'b1;
						end
						acse_pkg::MODE_BRACKET: begin
							emit.word.out_byte   = acse_pkg::CH_ESC;
							emit.word.byte_valid = 1'b1;
							if (out_free) begin
								state_d = acse_pkg::S_LB;
							end
						end
						default: begin
							emit.word.run_last = 1'b1;
						end
					endcase
					if (out_free) begin
						mode_d = acse_pkg::MODE_PLAIN;
					end
				end else begin
					case (mode_q)
						acse_pkg::MODE_ESCAPE: begin
							if (b == acse_pkg::CH_LBRACKET) begin
								mode_d    = acse_pkg::MODE_BRACKET;
								len_d     = '0;
								step_done = 1'b1;
							end else begin
								emit.req             = 1'b1;
								emit.word.out_byte   = acse_pkg::CH_ESC;
								emit.word.byte_valid = 1'b1;
								if (out_free) begin
									mode_d  = acse_pkg::MODE_PLAIN;
									state_d = acse_pkg::S_BYTE;
								end
							end
						end
						acse_pkg::MODE_BRACKET: begin
							if (b == acse_pkg::CH_M) begin
								mode_d    = acse_pkg::MODE_PLAIN;
								len_d     = '0;
								step_done = 1'b1;
							end else if (legal &&
								len_q < acse_pkg::LEN_W'(acse_pkg::MAX_SEQUENCE)) begin
								we        = 1'b1;
								len_d     = acse_pkg::LEN_W'(len_q + 1'b1);
								step_done = 1'b1;
							end else begin
								emit.req             = 1'b1;
								emit.word.out_byte   = acse_pkg::CH_ESC;
								emit.word.byte_valid = 1'b1;
								if (out_free) begin
									mode_d  = acse_pkg::MODE_PLAIN;
									state_d = acse_pkg::S_LB;
								end
							end
						end
						default: begin
							if (b == acse_pkg::CH_ESC) begin
								mode_d    = acse_pkg::MODE_ESCAPE;
								step_done = 1'b1;
							end else if (b == acse_pkg::CH_TAB) begin
								emit.req             = 1'b1;
								emit.word.out_byte   = acse_pkg::CH_SPACE;
								emit.word.byte_valid = 1'b1;
								if (out_free) begin
									mode_d  = acse_pkg::MODE_PLAIN;
									tab_d   = 3'd1;
									state_d = acse_pkg::S_TAB;
								end
							end else begin
								emit.req             = 1'b1;
								emit.word.out_byte   = b;
								emit.word.byte_valid = 1'b1;
								emit.word.run_last   = 1'b1;
								if (out_free) begin
									mode_d = acse_pkg::MODE_PLAIN;
								end
							end
						end
					endcase
				end
			end
			acse_pkg::S_LB: begin
				emit.req             = 1'b1;
				emit.word.out_byte   = acse_pkg::CH_LBRACKET;
				emit.word.byte_valid = 1'b1;
				emit.word.run_last   = (len_q == '0) && tail_none;
				if (out_free) begin
					if (len_q == '0) begin
						fin = 1'b1;
					end else begin
						state_d = acse_pkg::S_BUF;
						idx_d   = '0;
					end
				end
			end
			acse_pkg::S_BUF: begin
				emit.req             = 1'b1;
				emit.word.out_byte   = rdata;
				emit.word.byte_valid = 1'b1;
				emit.word.run_last   = at_end && tail_none;
				if (out_free) begin
					if (at_end) begin
						fin = 1'b1;
					end else begin
						idx_d = acse_pkg::IDX_W'(idx_q + 1'b1);
					end
				end
			end
			acse_pkg::S_TAB: begin
				emit.req             = 1'b1;
				emit.word.out_byte   = acse_pkg::CH_SPACE;
				emit.word.byte_valid = 1'b1;
				emit.word.run_last   = &tab_q;
				if (out_free) begin
					tab_d = 3'(tab_q + 1'b1);
				end
			end
			acse_pkg::S_BYTE: begin
				emit.req             = 1'b1;
				emit.word.out_byte   = b;
				emit.word.byte_valid = 1'b1;
				emit.word.run_last   = 1'b1;
			end
			default: begin
				state_d = acse_pkg::S_IDLE;
			end
		endcase

		if (fin) begin
			len_d = '0;
			idx_d = '0;
			if (!eot) begin
				if (b == acse_pkg::CH_ESC) begin
					mode_d = acse_pkg::MODE_ESCAPE;
				end else if (b == acse_pkg::CH_TAB) begin
					tab_d   = 3'd0;
					state_d = acse_pkg::S_TAB;
				end else begin
					state_d = acse_pkg::S_BYTE;
				end
			end
		end

		emit.word.stream_done = emit.word.run_last && eot;
		if (emit.req && out_free && emit.word.run_last) begin
			step_done = 1'b1;
		end

		text_stall = !(state_q == acse_pkg::S_IDLE || step_done);
		accept     = text_valid && !text_stall;
		if (accept) begin
			state_d = acse_pkg::S_DISPATCH;
		end else if (step_done) begin
			state_d = acse_pkg::S_IDLE;
		end
	end

endmodule

// ----- rtl/ansi_color_strip_tab_expand_unit.sv -----
// Strips ANSI color sequences (ESC '[' digits and semicolons 'm') from a byte stream and
// expands each tab into eight spaces; every result word but the empty one that closes an
// end of text after plain text carries one output byte, and the word that closes the
// results of an input is marked with run_last. Ordinary text flows at one byte per cycle
// while the output is not stalled. Any input that emits several bytes holds off the next
// input until its last byte is taken, because the single output register delivers at most
// one word per cycle: so do a tab, an ESC followed by another byte, and a broken or flushed
// sequence with its buffered bytes plus whatever the breaking byte itself emits. Buffered
// digits and semicolons live in a 16-entry RAM with one read port that is read back one
// entry per cycle during a flush while the output is free; it needs no clearing after
// reset. An input is taken while a finished word still waits at the output.
module ansi_color_strip_tab_expand_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  acse_pkg::in_word_t  text_data,
	output logic                result_valid,
	input  logic                result_stall,
	output acse_pkg::out_word_t result_data
);

	acse_pkg::emit_t     emit;
	acse_pkg::out_word_t data_q;
	logic                valid_q;
	logic                out_free;

	assign out_free = !valid_q || !result_stall;

	acse_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_data (text_data),
		.out_free  (out_free),
		.emit      (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.req && out_free) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.req && out_free) begin
			data_q <= emit.word;
		end
	end

	assign result_valid = valid_q;
	assign result_data  = data_q;

	// A word without a character only ever closes an end of text.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.byte_valid |->
			result_data.stream_done && result_data.run_last && result_data.out_byte == 8'd0)
		else $error("empty word that does not close the stream");

	// The core never offers a word that the output register cannot take and then drops it.
	a_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		emit.req && !out_free |=> result_valid && $stable(result_data))
		else $error("output word lost while the sink stalls");

	// The end of a stream is always the last word of its input.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.stream_done |-> result_data.run_last)
		else $error("stream end on a word that is not the last of its input");

endmodule
